// ===== hw/rtl/ipc_pkg.sv =====
`timescale 1ns / 1ps

package ipc_pkg;

  // result classes
  typedef enum logic [3:0] {
    CLS_NULL      = 4'd0,
    CLS_TCP       = 4'd1,
    CLS_SYN       = 4'd2,
    CLS_ACK       = 4'd3,
    CLS_FTP       = 4'd4,
    CLS_UDP       = 4'd5,
    CLS_DNS       = 4'd6,
    CLS_MIP       = 4'd7,
    CLS_ICMP      = 4'd8,
    CLS_USER_HIGH = 4'd9,
    CLS_INVALID   = 4'd10
  } ipc_class_t;

  // configuration register indexes
  localparam logic [1:0] REG_PRIO_EN  = 2'd0;
  localparam logic [1:0] REG_FTP_PORT = 2'd1;
  localparam logic [1:0] REG_DNS_PORT = 2'd2;
  localparam logic [1:0] REG_MIP_PORT = 2'd3;

  // ip versions and transport protocol numbers
  localparam logic [3:0] IP_V4        = 4'd4;
  localparam logic [3:0] IP_V6        = 4'd6;
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  // icmp message types
  localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [7:0] ICMP6_ECHO_REQ    = 8'd128;
  localparam logic [7:0] ICMP6_ECHO_REPLY  = 8'd129;

  localparam logic [6:0]  IPV6_HDR_LEN = 7'd40;
  localparam logic [15:0] BYTE_CNT_MAX = 16'hFFFF;

  // per-packet captured header fields
  typedef struct packed {
    logic [15:0] byte_count;
    logic [3:0]  ip_version;
    logic [6:0]  ip_header_length;
    logic [16:0] ip_total_length;
    logic [7:0]  transport_protocol;
    logic [12:0] fragment_offset;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  tcp_offset_byte;
    logic [7:0]  tcp_flags_byte;
    logic [15:0] udp_length;
    logic [7:0]  icmp_type;
  } ipc_pkt_t;

  // finished packet handed to the classifier
  typedef struct packed {
    ipc_pkt_t    pkt;
    logic [15:0] data_len;
    logic        high_pri;
  } ipc_snap_t;

  typedef struct packed {
    logic        prio_en;
    logic [15:0] ftp_port;
    logic [15:0] dns_port;
    logic [15:0] mip_port;
  } ipc_cfg_t;

endpackage

// ===== hw/rtl/ipc_capture.sv =====
`timescale 1ns / 1ps

module ipc_capture (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              in_tuser,
  output logic              snap_valid,
  input  logic              snap_ready,
  output ipc_pkg::ipc_snap_t snap
);

  logic              in_valid_r, in_valid_nxt;
  logic [7:0]        byte_r;
  logic              last_r;
  logic              hp_r;
  ipc_pkg::ipc_pkt_t pkt_r, pkt_nxt, upd;
  logic [15:0]       pos;
  logic [15:0]       rel;
  logic [15:0]       cnt_inc;
  logic              adv;
  logic              in_acc;

  assign adv        = in_valid_r && (!last_r || snap_ready);
  assign in_tready  = !in_valid_r || adv;
  assign in_acc     = in_tvalid && in_tready;
  assign snap_valid = in_valid_r && last_r;

  always_comb begin
    upd     = pkt_r;
    pos     = pkt_r.byte_count;
    cnt_inc = (pos != ipc_pkg::BYTE_CNT_MAX) ? pos + 16'd1 : pos;
    if (pos == 16'd0) begin
      upd.ip_version = byte_r[7:4];
      if (byte_r[7:4] == ipc_pkg::IP_V4) begin
        upd.ip_header_length = {1'b0, byte_r[3:0], 2'b00};
      end else if (byte_r[7:4] == ipc_pkg::IP_V6) begin
        upd.ip_header_length = ipc_pkg::IPV6_HDR_LEN;
      end else begin
        upd.ip_header_length = 7'd0;
      end
    end
    if (upd.ip_version == ipc_pkg::IP_V4) begin
      if (pos == 16'd2) upd.ip_total_length = {1'b0, byte_r, 8'h00};
      if (pos == 16'd3) upd.ip_total_length = {1'b0, pkt_r.ip_total_length[15:8], byte_r};
      if (pos == 16'd9) upd.transport_protocol = byte_r;
    end else if (upd.ip_version == ipc_pkg::IP_V6) begin
      if (pos == 16'd4) upd.ip_total_length = {1'b0, byte_r, 8'h00};
      if (pos == 16'd5) begin
        upd.ip_total_length = {1'b0, pkt_r.ip_total_length[15:8], byte_r}
                              + {10'd0, ipc_pkg::IPV6_HDR_LEN};
      end
      if (pos == 16'd6) upd.transport_protocol = byte_r;
    end
    // fragment offset is read from bytes 6-7 whatever the version
    if (pos == 16'd6) upd.fragment_offset = {byte_r[4:0], pkt_r.fragment_offset[7:0]};
    if (pos == 16'd7) upd.fragment_offset = {pkt_r.fragment_offset[12:8], byte_r};
    rel = pos - {9'd0, upd.ip_header_length};
    if (pos >= {9'd0, upd.ip_header_length}) begin
      case (rel)
        16'd0: begin
          upd.source_port[15:8] = byte_r;
          upd.icmp_type         = byte_r;
        end
        16'd1:  upd.source_port[7:0]       = byte_r;
        16'd2:  upd.destination_port[15:8] = byte_r;
        16'd3:  upd.destination_port[7:0]  = byte_r;
        16'd4:  upd.udp_length[15:8]       = byte_r;
        16'd5:  upd.udp_length[7:0]        = byte_r;
        16'd12: upd.tcp_offset_byte        = byte_r;
        16'd13: upd.tcp_flags_byte         = byte_r;
        default: ;
      endcase
    end

    pkt_nxt = pkt_r;
    if (adv) begin
      if (last_r) begin
        pkt_nxt = '0;
      end else begin
        pkt_nxt            = upd;
        pkt_nxt.byte_count = cnt_inc;
      end
    end

    in_valid_nxt = (in_valid_r && !adv) || in_acc;

    snap.pkt      = upd;
    snap.data_len = cnt_inc;
    snap.high_pri = hp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      pkt_r      <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      pkt_r      <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
      hp_r   <= in_tuser;
    end
  end

endmodule

// ===== hw/rtl/ipc_classify.sv =====
`timescale 1ns / 1ps

module ipc_classify (
  input  logic               clk,
  input  logic               rst_n,
  input  ipc_pkg::ipc_cfg_t  cfg,
  input  logic               snap_valid,
  output logic               snap_ready,
  input  ipc_pkg::ipc_snap_t snap,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata
);

  logic                 cls_valid_r, cls_valid_nxt;
  ipc_pkg::ipc_snap_t   snap_r;
  logic                 out_valid_r, out_valid_nxt;
  ipc_pkg::ipc_class_t  class_r, class_nxt;
  logic [15:0]          trace_r;
  logic                 out_free;
  logic                 snap_acc;

  logic [16:0] dl, hl, tot, hl_thl, hl_20, hl_8, trace_full;
  logic [5:0]  thl;
  logic        hdr_bad, l4_ok;
  logic [7:0]  proto;

  assign out_free   = !out_valid_r || out_tready;
  assign snap_ready = !cls_valid_r || out_free;
  assign snap_acc   = snap_valid && snap_ready;

  always_comb begin
    dl     = {1'b0, snap_r.data_len};
    hl     = {10'd0, snap_r.pkt.ip_header_length};
    tot    = snap_r.pkt.ip_total_length;
    thl    = {snap_r.pkt.tcp_offset_byte[7:4], 2'b00};
    hl_thl = hl + {11'd0, thl};
    hl_20  = hl + 17'd20;
    hl_8   = hl + 17'd8;
    proto  = snap_r.pkt.transport_protocol;

    hdr_bad = (dl <= 17'd20)
           || ((snap_r.pkt.ip_version != ipc_pkg::IP_V4)
               && (snap_r.pkt.ip_version != ipc_pkg::IP_V6))
           || (dl < tot) || (tot < hl);

    l4_ok      = 1'b1;
    class_nxt  = ipc_pkg::CLS_NULL;
    trace_full = hl;

    if (proto == ipc_pkg::PROTO_TCP) begin
      l4_ok = (dl >= hl_20) && (dl >= hl_thl);
      if (tot == hl_thl) begin
        trace_full = tot;
        if (snap_r.pkt.tcp_flags_byte[1]) begin
          class_nxt = ipc_pkg::CLS_SYN;
        end else if (snap_r.pkt.tcp_flags_byte[4]) begin
          class_nxt = ipc_pkg::CLS_ACK;
        end else begin
          class_nxt = ipc_pkg::CLS_TCP;
        end
      end else begin
        class_nxt  = (snap_r.pkt.destination_port == cfg.ftp_port) ?
                     ipc_pkg::CLS_FTP : ipc_pkg::CLS_TCP;
        trace_full = ((snap_r.pkt.source_port == cfg.ftp_port)
                      || (snap_r.pkt.destination_port == cfg.ftp_port)) ? tot : hl_thl;
      end
    end else if (proto == ipc_pkg::PROTO_UDP) begin
      l4_ok = (dl >= hl_8) && (snap_r.pkt.udp_length >= 16'd8);
      if (snap_r.pkt.destination_port == cfg.dns_port) begin
        class_nxt = ipc_pkg::CLS_DNS;
      end else if (snap_r.pkt.destination_port == cfg.mip_port) begin
        class_nxt = ipc_pkg::CLS_MIP;
      end else begin
        class_nxt = ipc_pkg::CLS_UDP;
      end
      trace_full = ((snap_r.pkt.source_port == cfg.dns_port)
                    || (snap_r.pkt.destination_port == cfg.dns_port)) ? tot : hl_8;
    end else if (proto == ipc_pkg::PROTO_ICMP) begin
      l4_ok      = dl >= hl_8;
      class_nxt  = ((snap_r.pkt.fragment_offset == 13'd0)
                    && ((snap_r.pkt.icmp_type == ipc_pkg::ICMP_ECHO_REQUEST)
                        || (snap_r.pkt.icmp_type == ipc_pkg::ICMP_ECHO_REPLY))) ?
                   ipc_pkg::CLS_ICMP : ipc_pkg::CLS_NULL;
      trace_full = hl_8;
    end else if (proto == ipc_pkg::PROTO_ICMPV6) begin
      l4_ok      = dl >= hl_8;
      class_nxt  = ((snap_r.pkt.icmp_type == ipc_pkg::ICMP6_ECHO_REQ)
                    || (snap_r.pkt.icmp_type == ipc_pkg::ICMP6_ECHO_REPLY)) ?
                   ipc_pkg::CLS_ICMP : ipc_pkg::CLS_NULL;
      trace_full = hl_8;
    end

    if (!l4_ok) begin
      class_nxt  = ipc_pkg::CLS_INVALID;
      trace_full = 17'd0;
    end
    if (cfg.prio_en && snap_r.high_pri) begin
      class_nxt = ipc_pkg::CLS_USER_HIGH;
    end
    if (hdr_bad) begin
      class_nxt  = ipc_pkg::CLS_INVALID;
      trace_full = 17'd0;
    end

    cls_valid_nxt = (cls_valid_r && !out_free) || snap_acc;
    out_valid_nxt = (out_valid_r && !out_tready) || (cls_valid_r && out_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cls_valid_r <= cls_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_acc) begin
      snap_r <= snap;
    end
    if (cls_valid_r && out_free) begin
      class_r <= class_nxt;
      trace_r <= trace_full[15:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, trace_r, class_r};

endmodule

// ===== hw/rtl/ip_packet_type_classifier.sv =====
`timescale 1ns / 1ps
// path: after its last byte transaction a packet's result passes the input, snapshot and output registers
// throughput: one packet byte per cycle while in_tready is high; each byte only updates captured header fields;
// two results can wait in the classifier and output registers, a further last byte holds input
// reset: synchronous, active low; clears captured fields, valid flags and restores
// the configuration registers to override off, ftp 21, dns 53, mobile ip 434

module ip_packet_type_classifier (
  input  logic        clk,
  input  logic        rst_n,
  // input stream of packet bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] packet_byte
  input  logic        in_tlast,   // last_byte
  input  logic        in_tuser,   // [0] high_priority
  // result stream, one transaction per packet
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] packet_class, [19:4] trace_length, [23:20] zero
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ipc_pkg::ipc_cfg_t  cfg_r, cfg_nxt;
  ipc_pkg::ipc_snap_t snap;
  logic               snap_valid;
  logic               snap_ready;

  // writes are always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ipc_pkg::REG_PRIO_EN:  cfg_nxt.prio_en  = cfg_data[0];
        ipc_pkg::REG_FTP_PORT: cfg_nxt.ftp_port = cfg_data;
        ipc_pkg::REG_DNS_PORT: cfg_nxt.dns_port = cfg_data;
        ipc_pkg::REG_MIP_PORT: cfg_nxt.mip_port = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prio_en  <= 1'b0;
      cfg_r.ftp_port <= 16'd21;
      cfg_r.dns_port <= 16'd53;
      cfg_r.mip_port <= 16'd434;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register and per-packet field capture; hands over a snapshot at the last byte
  ipc_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  // snapshot register, class and trace length decision, output register
  ipc_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // an invalid packet never carries a trace length
  a_invalid_zero_trace: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[3:0] == ipc_pkg::CLS_INVALID)) |-> (out_tdata[19:4] == 16'd0))
    else $error("invalid class with nonzero trace length");

  // user-high only appears while the override is enabled
  a_user_high_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[3:0] == ipc_pkg::CLS_USER_HIGH)) |-> cfg_r.prio_en)
    else $error("user-high class with override disabled");

  // a snapshot is only offered for a last byte, so no result can follow reset at once
  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result transaction right after reset");
`endif

endmodule

// ===== test/ip_packet_type_classifier_tb.sv =====
`timescale 1ns / 1ps

module ip_packet_type_classifier_tb;

  localparam int CYCLE_LIMIT = 200000;  // every byte gapped and every result stalled, many times over
  localparam int SETTLE_CYCLES = 6;     // result passes the snapshot and output registers after the last byte
  localparam int PHASE_PKTS = 2;
  localparam int PHASE_BYTES = 40;

  // one packet of stimulus; the ports word holds source port high, destination port low
  typedef struct packed {
    logic [7:0]  vihl;
    logic [15:0] len_field;
    logic [7:0]  proto;
    logic [15:0] frag;
    logic [31:0] ports;
    logic [15:0] ulen;
    logic [7:0]  tcpoff;
    logic [7:0]  flags;
    logic [16:0] plen;
    logic        hp;
    logic        bad;
  } pkt_row_t;

  typedef struct packed {
    ipc_pkg::ipc_class_t cls;
    logic [15:0]         trace;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] packet_byte
  logic        in_tlast = 1'b0;    // last_byte
  logic        in_tuser = 1'b0;    // [0] high_priority
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [3:0] packet_class, [19:4] trace_length, [23:20] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = ipc_pkg::REG_PRIO_EN;
  logic [15:0] cfg_data = 16'h0000;

  ip_packet_type_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // classifier settings as the block should hold them
  logic        prio_on;
  logic [15:0] ftp_port_cfg;
  logic [15:0] dns_port_cfg;
  logic [15:0] mip_port_cfg;

  // header fields captured from the packet in flight
  logic [15:0] cap_pos;
  logic [3:0]  cap_ver;
  logic [6:0]  cap_hlen;
  logic [16:0] cap_tot;
  logic [7:0]  cap_proto;
  logic [12:0] cap_frag;
  logic [15:0] cap_sport;
  logic [15:0] cap_dport;
  logic [7:0]  cap_tcpoff;
  logic [7:0]  cap_flags;
  logic [15:0] cap_ulen;
  logic [7:0]  cap_icmp;

  result_t     pending_classes[$];  // classes still owed by the block, oldest first
  pkt_row_t    rows[$];
  logic [7:0]  pkt_bytes[$];
  int          mismatches = 0;
  int          burst_left = 0;
  int unsigned stall_tick = 0;
  logic [31:0] stall_bits = '1;

  task automatic clear_capture();
    cap_pos = '0; cap_ver = '0; cap_hlen = '0; cap_tot = '0; cap_proto = '0;
    cap_frag = '0; cap_sport = '0; cap_dport = '0; cap_tcpoff = '0; cap_flags = '0;
    cap_ulen = '0; cap_icmp = '0;
  endtask

  // class and trace length of the finished packet, dl bytes long
  function automatic result_t classify_packet(input int unsigned dl, input logic hp);
    int unsigned         hl, tot, thl, t;
    logic                l4_ok;
    ipc_pkg::ipc_class_t c;
    result_t             r;
    hl = {25'd0, cap_hlen};
    tot = {15'd0, cap_tot};
    thl = {26'd0, cap_tcpoff[7:4], 2'b00};
    l4_ok = 1'b1;
    c = ipc_pkg::CLS_NULL;
    t = hl;
    // broken ip header
    if (dl <= 20 || (cap_ver != ipc_pkg::IP_V4 && cap_ver != ipc_pkg::IP_V6)
        || dl < tot || tot < hl) begin
      r.cls = ipc_pkg::CLS_INVALID;
      r.trace = '0;
      return r;
    end
    case (cap_proto)
      ipc_pkg::PROTO_TCP: begin
        l4_ok = (dl >= hl + 20) && (dl >= hl + thl);
        if (tot == hl + thl) begin
          // header-only segment: flags decide
          t = tot;
          if (cap_flags[1]) c = ipc_pkg::CLS_SYN;
          else if (cap_flags[4]) c = ipc_pkg::CLS_ACK;
          else c = ipc_pkg::CLS_TCP;
        end else begin
          c = (cap_dport == ftp_port_cfg) ? ipc_pkg::CLS_FTP : ipc_pkg::CLS_TCP;
          if (cap_sport == ftp_port_cfg || cap_dport == ftp_port_cfg) t = tot;
          else t = hl + thl;
        end
      end
      ipc_pkg::PROTO_UDP: begin
        l4_ok = (dl >= hl + 8) && (cap_ulen >= 16'd8);
        if (cap_dport == dns_port_cfg) c = ipc_pkg::CLS_DNS;
        else if (cap_dport == mip_port_cfg) c = ipc_pkg::CLS_MIP;
        else c = ipc_pkg::CLS_UDP;
        if (cap_sport == dns_port_cfg || cap_dport == dns_port_cfg) t = tot;
        else t = hl + 8;
      end
      ipc_pkg::PROTO_ICMP: begin
        // fragment word taken from bytes 6-7 whatever the ip version
        l4_ok = (dl >= hl + 8);
        if (cap_frag == '0 && (cap_icmp == ipc_pkg::ICMP_ECHO_REQUEST
                               || cap_icmp == ipc_pkg::ICMP_ECHO_REPLY))
          c = ipc_pkg::CLS_ICMP;
        t = hl + 8;
      end
      ipc_pkg::PROTO_ICMPV6: begin
        l4_ok = (dl >= hl + 8);
        if (cap_icmp == ipc_pkg::ICMP6_ECHO_REQ || cap_icmp == ipc_pkg::ICMP6_ECHO_REPLY)
          c = ipc_pkg::CLS_ICMP;
        t = hl + 8;
      end
      default: ;
    endcase
    if (!l4_ok) begin
      c = ipc_pkg::CLS_INVALID;
      t = 0;
    end
    if (prio_on && hp) c = ipc_pkg::CLS_USER_HIGH;
    r.cls = c;
    r.trace = t[15:0];
    return r;
  endfunction

  // capture one accepted byte; on the last one hand back the packet's result
  task automatic track_byte(input logic [7:0] b, input logic last, input logic hp,
                            output logic done, output result_t res);
    int unsigned p, rel, dl, hl;
    p = {16'd0, cap_pos};
    done = 1'b0;
    res = '0;
    if (p == 0) begin
      cap_ver = b[7:4];
      if (cap_ver == ipc_pkg::IP_V4) cap_hlen = {1'b0, b[3:0], 2'b00};
      else if (cap_ver == ipc_pkg::IP_V6) cap_hlen = ipc_pkg::IPV6_HDR_LEN;
      else cap_hlen = '0;
    end
    if (cap_ver == ipc_pkg::IP_V4) begin
      if (p == 2) cap_tot = {1'b0, b, 8'h00};
      if (p == 3) cap_tot = {1'b0, cap_tot[15:8], b};
      if (p == 9) cap_proto = b;
    end else if (cap_ver == ipc_pkg::IP_V6) begin
      // payload length plus the fixed header
      if (p == 4) cap_tot = {1'b0, b, 8'h00};
      if (p == 5) cap_tot = {1'b0, cap_tot[15:8], b} + 17'd40;
      if (p == 6) cap_proto = b;
    end
    if (p == 6) cap_frag[12:8] = b[4:0];
    if (p == 7) cap_frag[7:0] = b;
    hl = {25'd0, cap_hlen};
    if (p >= hl) begin
      rel = p - hl;
      case (rel)
        0: begin
          cap_sport[15:8] = b;
          cap_icmp = b;
        end
        1: cap_sport[7:0] = b;
        2: cap_dport[15:8] = b;
        3: cap_dport[7:0] = b;
        4: cap_ulen[15:8] = b;
        5: cap_ulen[7:0] = b;
        12: cap_tcpoff = b;
        13: cap_flags = b;
        default: ;
      endcase
    end
    if (!last) begin
      if (cap_pos != ipc_pkg::BYTE_CNT_MAX) cap_pos = cap_pos + 16'd1;
    end else begin
      // byte count saturates, so overlong packets read as 65535 bytes
      dl = (cap_pos != ipc_pkg::BYTE_CNT_MAX) ? p + 1 : 32'd65535;
      res = classify_packet(dl, hp);
      done = 1'b1;
      clear_capture();
    end
  endtask

  task automatic log_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ipc_pkg::REG_PRIO_EN:  prio_on = val[0];
      ipc_pkg::REG_FTP_PORT: ftp_port_cfg = val;
      ipc_pkg::REG_DNS_PORT: dns_port_cfg = val;
      ipc_pkg::REG_MIP_PORT: mip_port_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic prio, input logic [15:0] ftp,
                               input logic [15:0] dns, input logic [15:0] mip);
    logic [15:0] prio_word;
    // upper bits of the enable write are junk, only bit 0 counts
    prio_word = 16'($urandom_range(0, 65535));
    prio_word[0] = prio;
    write_reg(ipc_pkg::REG_PRIO_EN, prio_word);
    write_reg(ipc_pkg::REG_FTP_PORT, ftp);
    write_reg(ipc_pkg::REG_DNS_PORT, dns);
    write_reg(ipc_pkg::REG_MIP_PORT, mip);
  endtask

  // idle the input and wait for every owed result, then let the pipe settle
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_classes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic place(input int unsigned idx, input logic [7:0] v);
    if (idx < pkt_bytes.size()) pkt_bytes[idx] = v;
  endtask

  // lay out a packet: random filler, transport fields, then the ip fields on top
  task automatic build_packet(input pkt_row_t r);
    int unsigned hl;
    pkt_bytes.delete();
    for (int i = 0; i < r.plen; i++) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    if (r.vihl[7:4] == ipc_pkg::IP_V4) hl = {26'd0, r.vihl[3:0], 2'b00};
    else if (r.vihl[7:4] == ipc_pkg::IP_V6) hl = {25'd0, ipc_pkg::IPV6_HDR_LEN};
    else hl = 0;
    place(hl, r.ports[31:24]);
    place(hl + 1, r.ports[23:16]);
    place(hl + 2, r.ports[15:8]);
    place(hl + 3, r.ports[7:0]);
    place(hl + 4, r.ulen[15:8]);
    place(hl + 5, r.ulen[7:0]);
    place(hl + 12, r.tcpoff);
    place(hl + 13, r.flags);
    place(6, r.frag[15:8]);
    place(7, r.frag[7:0]);
    if (r.vihl[7:4] == ipc_pkg::IP_V6) begin
      place(4, r.len_field[15:8]);
      place(5, r.len_field[7:0]);
      place(6, r.proto);
    end else begin
      place(2, r.len_field[15:8]);
      place(3, r.len_field[7:0]);
      place(9, r.proto);
    end
    place(0, r.vihl);
  endtask

  // push the packet through the input in bursts; typed rows owe invalid with zero trace
  task automatic send_packet(input logic hp, input logic typed);
    int      n, gap;
    logic    done;
    logic    lst, usr;
    result_t res;
    n = pkt_bytes.size();
    for (int i = 0; i < n; i++) begin
      lst = (i == n - 1);
      usr = lst ? hp : 1'($urandom_range(0, 1));
      @(negedge clk);
      in_tvalid <= 1'b1;
      in_tdata <= pkt_bytes[i];
      in_tlast <= lst;
      in_tuser <= usr;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      track_byte(pkt_bytes[i], lst, usr, done, res);
      if (done) begin
        if (typed) begin
          res.cls = ipc_pkg::CLS_INVALID;
          res.trace = '0;
        end
        pending_classes.push_back(res);
      end
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 20);
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic add_row(input logic [7:0] vihl, input logic [15:0] len, input logic [7:0] proto,
                         input logic [15:0] frag, input logic [31:0] ports,
                         input logic [15:0] ulen, input logic [7:0] tcpoff,
                         input logic [7:0] flags, input int plen, input logic hp,
                         input logic bad);
    pkt_row_t r;
    r.vihl = vihl; r.len_field = len; r.proto = proto; r.frag = frag; r.ports = ports;
    r.ulen = ulen; r.tcpoff = tcpoff; r.flags = flags; r.plen = 17'(plen); r.hp = hp;
    r.bad = bad;
    rows.push_back(r);
  endtask

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 5))
      0: return ftp_port_cfg;
      1: return dns_port_cfg;
      2: return mip_port_cfg;
      3: return 16'h0000;
      4: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly well-formed packets with random content, some short or garbled
  function automatic pkt_row_t random_row();
    pkt_row_t    r;
    int unsigned hl, l4, tot, k;
    logic [3:0]  nib;
    nib = 4'($urandom_range(0, 15));
    k = $urandom_range(0, 99);
    if (k < 62) r.vihl = 8'h45;
    else if (k < 74) r.vihl = {ipc_pkg::IP_V4, nib};
    else if (k < 92) r.vihl = {ipc_pkg::IP_V6, nib};
    else r.vihl = 8'($urandom_range(0, 255));
    if (r.vihl[7:4] == ipc_pkg::IP_V4) hl = {26'd0, r.vihl[3:0], 2'b00};
    else hl = {25'd0, ipc_pkg::IPV6_HDR_LEN};
    k = $urandom_range(0, 99);
    if (k < 35) r.proto = ipc_pkg::PROTO_TCP;
    else if (k < 65) r.proto = ipc_pkg::PROTO_UDP;
    else if (k < 77) r.proto = ipc_pkg::PROTO_ICMP;
    else if (k < 89) r.proto = ipc_pkg::PROTO_ICMPV6;
    else r.proto = 8'($urandom_range(0, 255));
    r.ports = {pick_port(), pick_port()};
    if (r.proto == ipc_pkg::PROTO_ICMP || r.proto == ipc_pkg::PROTO_ICMPV6) begin
      case ($urandom_range(0, 4))
        0: r.ports[31:24] = ipc_pkg::ICMP_ECHO_REPLY;
        1: r.ports[31:24] = ipc_pkg::ICMP_ECHO_REQUEST;
        2: r.ports[31:24] = ipc_pkg::ICMP6_ECHO_REQ;
        3: r.ports[31:24] = ipc_pkg::ICMP6_ECHO_REPLY;
        default: ;
      endcase
    end
    r.frag = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 1)) r.frag = r.frag & 16'hE000;
    r.ulen = 16'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 65535));
    nib = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
    r.tcpoff = {nib, 4'($urandom_range(0, 15))};
    r.flags = 8'($urandom_range(0, 255));
    if (r.proto == ipc_pkg::PROTO_TCP)
      l4 = {26'd0, nib, 2'b00} + (($urandom_range(0, 1)) ? 32'd0 : $urandom_range(0, 40));
    else if (r.proto == ipc_pkg::PROTO_UDP || r.proto == ipc_pkg::PROTO_ICMP
             || r.proto == ipc_pkg::PROTO_ICMPV6)
      l4 = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : 8 + $urandom_range(0, 40);
    else l4 = $urandom_range(0, 40);
    tot = hl + l4;
    r.len_field = 16'((r.vihl[7:4] == ipc_pkg::IP_V6) ?
                      tot - {25'd0, ipc_pkg::IPV6_HDR_LEN} : tot);
    if ($urandom_range(0, 19) == 0) r.len_field = 16'($urandom_range(0, 65535));
    k = $urandom_range(0, 99);
    if (k < 75) r.plen = 17'(tot + $urandom_range(0, 3));
    else if (k < 90) r.plen = 17'($urandom_range(1, tot + 1));
    else r.plen = 17'($urandom_range(1, 100));
    if (r.plen == 0) r.plen = 17'd1;
    r.hp = 1'($urandom_range(0, 1));
    r.bad = 1'b0;
    return r;
  endfunction

  task automatic run_random(input int min_pkts, input int min_bytes);
    pkt_row_t r;
    int       pk, by;
    pk = 0;
    by = 0;
    while (pk < min_pkts || by < min_bytes) begin
      r = random_row();
      build_packet(r);
      by += pkt_bytes.size();
      send_packet(r.hp, 1'b0);
      pk++;
      // hold the sender until the output has caught up
      if (pk == min_pkts / 2) drain_results();
    end
    drain_results();
  endtask

  task automatic load_table();
    // vihl, len, proto, frag, ports,
    //   ulen, off, flags, plen, hp, bad
    add_row(8'h45, 16'd20, ipc_pkg::PROTO_TCP, 16'h0000, 32'h0015_0015,
            16'd8, 8'h50, 8'h02, 20, 1'b0, 1'b1);
    add_row(8'hFF, 16'd0, 8'd0, 16'h0000, 32'h0000_0000,
            16'd0, 8'h00, 8'h00, 1, 1'b1, 1'b1);
    add_row(8'h55, 16'd40, ipc_pkg::PROTO_TCP, 16'h0000, 32'h1234_5678,
            16'd8, 8'h50, 8'h00, 40, 1'b0, 1'b1);
    add_row(8'h00, 16'd21, ipc_pkg::PROTO_UDP, 16'h0000, 32'h0000_0035,
            16'd8, 8'h50, 8'h00, 21, 1'b0, 1'b1);
    add_row(8'h45, 16'd100, ipc_pkg::PROTO_UDP, 16'h0000, 32'h0035_0035,
            16'd40, 8'h50, 8'h00, 30, 1'b0, 1'b1);
    add_row(8'h4F, 16'd40, ipc_pkg::PROTO_UDP, 16'h0000, 32'h0035_0035,
            16'd40, 8'h50, 8'h00, 41, 1'b0, 1'b1);
    add_row(8'h60, 16'hFFFF, ipc_pkg::PROTO_UDP, 16'h0000, 32'h0035_0035,
            16'd40, 8'h50, 8'h00, 41, 1'b0, 1'b1);
    // tcp: header-only flag cases, ftp, plain
    add_row(8'h45, 16'd40, ipc_pkg::PROTO_TCP, 16'h0000, 32'hC000_0050,
            16'd0, 8'h50, 8'h02, 40, 1'b0, 1'b0);
    add_row(8'h45, 16'd40, ipc_pkg::PROTO_TCP, 16'h4000, 32'hC000_0050,
            16'd0, 8'h50, 8'h10, 44, 1'b1, 1'b0);
    add_row(8'h45, 16'd40, ipc_pkg::PROTO_TCP, 16'h0000, 32'hC000_0050,
            16'd0, 8'h5F, 8'hED, 40, 1'b0, 1'b0);
    add_row(8'h45, 16'd60, ipc_pkg::PROTO_TCP, 16'h0000, 32'hC000_0015,
            16'd0, 8'h50, 8'h18, 60, 1'b0, 1'b0);
    add_row(8'h45, 16'd50, ipc_pkg::PROTO_TCP, 16'h0000, 32'h0015_C000,
            16'd0, 8'h60, 8'h18, 50, 1'b0, 1'b0);
    add_row(8'h45, 16'd50, ipc_pkg::PROTO_TCP, 16'h0000, 32'hFFFF_0000,
            16'd0, 8'h50, 8'hFF, 55, 1'b0, 1'b0);
    add_row(8'h45, 16'd30, ipc_pkg::PROTO_TCP, 16'h0000, 32'h0015_0015,
            16'd0, 8'h50, 8'h02, 30, 1'b0, 1'b1);
    add_row(8'h45, 16'd45, ipc_pkg::PROTO_TCP, 16'h0000, 32'h0015_0015,
            16'd0, 8'hF0, 8'h02, 45, 1'b0, 1'b1);
    // udp: dns either side, mobile ip, short udp length, port extremes
    add_row(8'h45, 16'd30, ipc_pkg::PROTO_UDP, 16'h0000, 32'h1000_0035,
            16'd40, 8'h00, 8'h00, 30, 1'b0, 1'b0);
    add_row(8'h45, 16'd30, ipc_pkg::PROTO_UDP, 16'h0000, 32'h0035_03E8,
            16'd40, 8'h00, 8'h00, 34, 1'b0, 1'b0);
    add_row(8'h45, 16'd30, ipc_pkg::PROTO_UDP, 16'h0000, 32'h1000_01B2,
            16'd8, 8'h00, 8'h00, 30, 1'b1, 1'b0);
    add_row(8'h45, 16'd30, ipc_pkg::PROTO_UDP, 16'h0000, 32'h1000_1001,
            16'd7, 8'h00, 8'h00, 30, 1'b0, 1'b1);
    add_row(8'h4F, 16'd80, ipc_pkg::PROTO_UDP, 16'hFFFF, 32'hFFFF_FFFF,
            16'hFFFF, 8'hFF, 8'hFF, 80, 1'b0, 1'b0);
    // icmp: echo, fragment, short, ipv6 echo, ipv6 header with protocol 1
    add_row(8'h45, 16'd28, ipc_pkg::PROTO_ICMP, 16'h2000, 32'h0800_0000,
            16'd0, 8'h00, 8'h00, 28, 1'b0, 1'b0);
    add_row(8'h45, 16'd28, ipc_pkg::PROTO_ICMP, 16'h0001, 32'h0000_0000,
            16'd0, 8'h00, 8'h00, 28, 1'b0, 1'b0);
    add_row(8'h45, 16'd25, ipc_pkg::PROTO_ICMP, 16'h0000, 32'h0800_0000,
            16'd0, 8'h00, 8'h00, 25, 1'b0, 1'b1);
    add_row(8'h60, 16'd8, ipc_pkg::PROTO_ICMPV6, 16'h0000, 32'h8000_0000,
            16'd0, 8'h00, 8'h00, 48, 1'b0, 1'b0);
    add_row(8'h6F, 16'd8, ipc_pkg::PROTO_ICMP, 16'h0000, 32'h0800_0000,
            16'd0, 8'h00, 8'h00, 48, 1'b0, 1'b0);
    // other protocol, zero header length
    add_row(8'h45, 16'd20, 8'd200, 16'h0000, 32'h0000_0000,
            16'd0, 8'h00, 8'h00, 24, 1'b1, 1'b0);
    add_row(8'h40, 16'd30, ipc_pkg::PROTO_UDP, 16'h0000, 32'h0000_0000,
            16'd8, 8'h00, 8'h00, 30, 1'b0, 1'b0);
  endtask

  // receiver stall: a random ready pattern that is redrawn periodically, sometimes fully ready
  always @(negedge clk) begin
    if (stall_tick % 48 == 0) begin
      stall_bits = $urandom;
      if ($urandom_range(0, 3) == 0) stall_bits = '1;
    end
    out_tready <= stall_bits[stall_tick[4:0]];
    stall_tick++;
  end

  // compare each result transaction with the oldest owed class
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_classes.size() == 0) begin
        log_failure($sformatf("unexpected result transaction, tdata %h", out_tdata));
      end else begin
        want = pending_classes.pop_front();
        if (out_tdata[3:0] != want.cls || out_tdata[19:4] != want.trace
            || out_tdata[23:20] != 4'h0) begin
          log_failure($sformatf("mismatch: class exp %0d got %0d, trace exp %0d got %0d, pad %h",
                                want.cls, out_tdata[3:0], want.trace, out_tdata[19:4],
                                out_tdata[23:20]));
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    prio_on = 1'b0;
    ftp_port_cfg = 16'd21;
    dns_port_cfg = 16'd53;
    mip_port_cfg = 16'd434;
    clear_capture();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed packets under reset settings
    load_table();
    foreach (rows[i]) begin
      build_packet(rows[i]);
      send_packet(rows[i].hp, rows[i].bad);
    end
    drain_results();

    // random traffic under a spread of settings, extremes first
    apply_setting(1'b1, 16'h0000, 16'h0000, 16'h0000);
    run_random(PHASE_PKTS, PHASE_BYTES);
    apply_setting(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(PHASE_PKTS, PHASE_BYTES);
    apply_setting(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
    run_random(PHASE_PKTS, PHASE_BYTES);
    apply_setting(1'b1, 16'd21, 16'd53, 16'd434);
    run_random(PHASE_PKTS, PHASE_BYTES);
    apply_setting(1'b0, 16'd21, 16'd53, 16'd434);
    run_random(PHASE_PKTS, PHASE_BYTES);

    drain_results();
    if (mismatches == 0 && pending_classes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
